[hw/rtl/jfcm_pkg.sv]
// Package for the jet false-colour mapper: widths, colour constants,
// segment codes and configuration register indexes.
// No dependencies; used by jet_false_color_map and jfcm_checker.
package jfcm_pkg;

    // Default sample width on the input stream
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Range registers and derived widths
    localparam int REG_W   = 16;
    localparam int FRAC_W  = 16;            // fraction bits of t
    localparam int T_W     = FRAC_W + 1;    // t runs 0 .. 1.0 inclusive
    localparam int SEG_F_W = 14;            // fraction bits inside one segment
    localparam int CHAN_W  = 8;

    localparam logic signed [REG_W-1:0] RANGE_LOW_RST  = 16'sd0;
    localparam logic signed [REG_W-1:0] RANGE_HIGH_RST = 16'sd32767;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'd1;

    // Colour constants
    localparam logic [CHAN_W-1:0] BASE_BLUE = 8'd144;
    localparam logic [CHAN_W-1:0] FULL      = 8'd255;
    localparam logic [CHAN_W-1:0] BLUE_RISE = 8'd111;   // FULL - BASE_BLUE
    localparam logic [CHAN_W-1:0] ZERO      = 8'd0;

    // Segments of the jet scale
    localparam logic [1:0] SEG_DARK   = 2'd0;   // dark blue to blue
    localparam logic [1:0] SEG_CYAN   = 2'd1;   // blue to cyan
    localparam logic [1:0] SEG_YELLOW = 2'd2;   // cyan to yellow
    localparam logic [1:0] SEG_RED    = 2'd3;   // yellow to red

endpackage

[hw/rtl/jet_false_color_map.sv]
// Jet false-colour mapper: signed sample in, packed BGR word out; depends on jfcm_pkg.
// Throughput: one word per cycle while m_ is not stalled; the 17-stage restoring divider
// (one quotient bit per stage) plus three preparation stages and one colour stage set
// the depth. A stall on m_ holds every stage; aresetn (synchronous, active low) empties
// the pipe and loads range_low = 0, range_high = 32767.
module jet_false_color_map #(
    parameter int SAMPLE_WIDTH = jfcm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // input stream
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,   // sample_value
    // result stream
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [3*jfcm_pkg::CHAN_W-1:0]            m_tdata,   // blue_out, green_out, red_out
    // configuration write channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [jfcm_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [jfcm_pkg::REG_W-1:0]               cfg_data
);

    localparam int REG_W  = jfcm_pkg::REG_W;
    localparam int CMP_W  = (SAMPLE_WIDTH > REG_W) ? SAMPLE_WIDTH : REG_W;
    localparam int T_W    = jfcm_pkg::T_W;
    localparam int FW     = jfcm_pkg::FRAC_W;
    localparam int SFW    = jfcm_pkg::SEG_F_W;
    localparam int CW     = jfcm_pkg::CHAN_W;

    // whole pipe moves when the output register is free or being drained
    logic advance;
    logic m_valid_reg;

    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    // configuration registers
    logic signed [REG_W-1:0] range_low_reg, range_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= jfcm_pkg::RANGE_LOW_RST;
            range_high_reg <= jfcm_pkg::RANGE_HIGH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                jfcm_pkg::REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                jfcm_pkg::REG_RANGE_HIGH: range_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: capture sample, order the bounds ----------------
    logic                           vld1_reg;
    logic signed [SAMPLE_WIDTH-1:0] v1_reg;
    logic signed [REG_W-1:0]        lo1_reg, hi1_reg;
    logic                           swap_next;

    assign swap_next = range_low_reg > range_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (advance) begin
            vld1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            v1_reg  <= s_tdata[SAMPLE_WIDTH-1:0];
            lo1_reg <= swap_next ? range_high_reg : range_low_reg;
            hi1_reg <= swap_next ? range_low_reg  : range_high_reg;
        end
    end

    // ---------------- stage 2: clamp, span ----------------
    logic                    vld2_reg;
    logic signed [REG_W-1:0] vc2_reg, lo2_reg;
    logic [REG_W-1:0]        span2_reg;
    logic signed [CMP_W-1:0] v_ext, lo_ext, hi_ext;
    logic signed [REG_W-1:0] vc_next;
    logic [REG_W-1:0]        span_raw, span_next;

    assign v_ext  = CMP_W'(v1_reg);
    assign lo_ext = CMP_W'(lo1_reg);
    assign hi_ext = CMP_W'(hi1_reg);

    always_comb begin
        priority if (v_ext > hi_ext) begin
            vc_next = hi1_reg;
        end else if (v_ext < lo_ext) begin
            vc_next = lo1_reg;
        end else begin
            vc_next = v_ext[REG_W-1:0];
        end
    end

    // hi >= lo, so the difference fits unsigned; a zero span counts as one
    assign span_raw  = REG_W'(hi1_reg - lo1_reg);
    assign span_next = (span_raw == '0) ? REG_W'(1) : span_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (advance) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            vc2_reg   <= vc_next;
            lo2_reg   <= lo1_reg;
            span2_reg <= span_next;
        end
    end

    // ---------------- stage 3: offset from the low bound ----------------
    logic             vld3_reg;
    logic [REG_W-1:0] d3_reg, span3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (advance) begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            d3_reg    <= REG_W'(vc2_reg - lo2_reg);
            span3_reg <= span2_reg;
        end
    end

    // ---------------- divider: t = (d << 16) / span, one bit a stage ----------------
    logic             dvld_reg [0:FW];
    logic [REG_W-1:0] rem_reg  [0:FW-1];
    logic [REG_W-1:0] dspan_reg[0:FW-1];
    logic [T_W-1:0]   q_reg    [0:FW];
    logic             top_next;

    // integer bit: d never exceeds span, so it is set only when d equals span
    assign top_next = d3_reg >= span3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dvld_reg[0] <= 1'b0;
        end else if (advance) begin
            dvld_reg[0] <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg[0]   <= top_next ? '0 : d3_reg;
            dspan_reg[0] <= span3_reg;
            q_reg[0]     <= T_W'(top_next);
        end
    end

    for (genvar k = 1; k <= FW; k++) begin : g_div
        logic [REG_W:0]   shifted;
        logic             bit_next;

        // shift in a zero, subtract the span where it fits
        assign shifted  = {rem_reg[k-1], 1'b0};
        assign bit_next = shifted >= {1'b0, dspan_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvld_reg[k] <= 1'b0;
            end else if (advance) begin
                dvld_reg[k] <= dvld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                q_reg[k] <= {q_reg[k-1][T_W-2:0], bit_next};
            end
        end

        // carry remainder and divisor on, except past the last quotient bit
        if (k < FW) begin : g_carry
            logic [REG_W-1:0] rem_next;

            assign rem_next = bit_next ? REG_W'(shifted - {1'b0, dspan_reg[k-1]})
                                       : shifted[REG_W-1:0];

            always_ff @(posedge aclk) begin
                if (advance) begin
                    rem_reg[k]   <= rem_next;
                    dspan_reg[k] <= dspan_reg[k-1];
                end
            end
        end
    end

    // ---------------- colour stage into the output register ----------------
    logic [T_W-1:0]   t_val;
    logic [1:0]       seg;
    logic [SFW-1:0]   f_val;
    logic [SFW:0]     f_mirror;
    logic [SFW+6:0]   blue_ramp;    // 111 * f
    logic [SFW+7:0]   up_ramp;      // 255 * f
    logic [SFW+7:0]   down_ramp;    // 255 * (16384 - f)
    logic [CW-1:0]    up_val, down_val;
    logic [CW-1:0]    blue_next, green_next, red_next;
    logic [CW-1:0]    blue_reg, green_reg, red_reg;

    assign t_val    = q_reg[FW];
    assign seg      = t_val[FW-1:SFW];
    assign f_val    = t_val[SFW-1:0];
    assign f_mirror = (SFW+1)'(1 << SFW) - (SFW+1)'(f_val);

    assign blue_ramp = (SFW+7)'(f_val) * (SFW+7)'(jfcm_pkg::BLUE_RISE);
    assign up_ramp   = (SFW+8)'(f_val) * (SFW+8)'(jfcm_pkg::FULL);
    assign down_ramp = (SFW+8)'(f_mirror) * (SFW+8)'(jfcm_pkg::FULL);
    assign up_val    = up_ramp[SFW+CW-1:SFW];
    assign down_val  = down_ramp[SFW+CW-1:SFW];

    always_comb begin
        blue_next  = jfcm_pkg::ZERO;
        green_next = jfcm_pkg::ZERO;
        red_next   = jfcm_pkg::ZERO;
        if (t_val[FW]) begin
            // top of range: pure red
            red_next = jfcm_pkg::FULL;
        end else begin
            unique case (seg)
                jfcm_pkg::SEG_DARK: begin
                    blue_next = jfcm_pkg::BASE_BLUE + CW'(blue_ramp[SFW+6:SFW]);
                end
                jfcm_pkg::SEG_CYAN: begin
                    blue_next  = jfcm_pkg::FULL;
                    green_next = up_val;
                end
                jfcm_pkg::SEG_YELLOW: begin
                    red_next   = up_val;
                    green_next = jfcm_pkg::FULL;
                    blue_next  = jfcm_pkg::FULL - up_val;
                end
                jfcm_pkg::SEG_RED: begin
                    red_next   = jfcm_pkg::FULL;
                    green_next = down_val;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= dvld_reg[FW];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            blue_reg  <= blue_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {red_reg, green_reg, blue_reg};

endmodule

[hw/rtl/jfcm_checker.sv]
// Port-level checks for the jet false-colour mapper, bound to its top level.
// Depends on jfcm_pkg and jet_false_color_map.
module jfcm_port_props (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [3*jfcm_pkg::CHAN_W-1:0]   m_tdata
);

    localparam int CW = jfcm_pkg::CHAN_W;

    // hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // back-pressure on the input only when the output is stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // full red only in the last segment or at the top of range, where blue is gone
    a_red_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3*CW-1:2*CW] == jfcm_pkg::FULL)
        |-> m_tdata[CW-1:0] == jfcm_pkg::ZERO)
        else $error("full red with blue present");

    // no red means the cold end, where blue never drops below its base
    a_cold_blue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3*CW-1:2*CW] == jfcm_pkg::ZERO)
        |-> m_tdata[CW-1:0] >= jfcm_pkg::BASE_BLUE)
        else $error("cold colour with blue below base");

endmodule

bind jet_false_color_map jfcm_port_props u_port_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/jfcm_checker.sv]
// Scoreboard for the jet false-colour mapper: watches the configuration,
// input and result channels, predicts each colour word and compares it.
// Depends on jfcm_pkg; instantiated by jet_false_color_map_tb.
`timescale 1ns / 1ps

module jfcm_checker
    import jfcm_pkg::*;
(
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [((SAMPLE_WIDTH_DEF + 7) / 8) * 8 - 1:0] s_tdata,   // sample_value
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [3*CHAN_W-1:0]                m_tdata,   // blue_out, green_out, red_out
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [CFG_IDX_W-1:0]               cfg_index,
    input  logic [REG_W-1:0]                   cfg_data,
    output int                                 fail_count,
    output int                                 checked_words,
    output int                                 pending_words
);

    // Packed in the order of m_tdata: red on top, blue in the lowest byte
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } bgr_t;

    string field_name [3] = '{"blue", "green", "red"};

    logic signed [REG_W-1:0] range_lo;
    logic signed [REG_W-1:0] range_hi;
    bgr_t                    colour_q [$];
    bgr_t                    want;
    bgr_t                    got;

    // Clamp, normalise to t and pick the colour on the jet scale
    function automatic bgr_t jet_colour(input logic signed [SAMPLE_WIDTH_DEF-1:0] sample,
                                        input logic signed [REG_W-1:0] lo_reg,
                                        input logic signed [REG_W-1:0] hi_reg);
        longint     lo;
        longint     hi;
        longint     v;
        longint     span;
        longint     t;
        longint     f;
        longint     tmp;
        logic [1:0] seg;
        bgr_t       c;
        lo = lo_reg;
        hi = hi_reg;
        v  = sample;
        if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        span = hi - lo;
        if (span == 0) begin
            span = 1;
        end
        if (v > hi) begin
            v = hi;
        end
        if (v < lo) begin
            v = lo;
        end
        t = ((v - lo) * 65536) / span;
        c = '0;
        if (t >= 65536) begin
            c.red = FULL;
        end else begin
            f   = t & ((1 << SEG_F_W) - 1);
            seg = 2'(t >> SEG_F_W);
            case (seg)
                SEG_DARK: begin
                    c.blue = BASE_BLUE + CHAN_W'((longint'(BLUE_RISE) * f) >> SEG_F_W);
                end
                SEG_CYAN: begin
                    c.blue  = FULL;
                    c.green = CHAN_W'((longint'(FULL) * f) >> SEG_F_W);
                end
                SEG_YELLOW: begin
                    c.red   = CHAN_W'((longint'(FULL) * f) >> SEG_F_W);
                    c.green = FULL;
                    c.blue  = FULL - c.red;
                end
                default: begin
                    c.red   = FULL;
                    c.green = CHAN_W'((longint'(FULL) * ((1 << SEG_F_W) - f)) >> SEG_F_W);
                end
            endcase
        end
        return c;
    endfunction

    // Track the range registers, queue predictions, compare results
    always @(posedge aclk) begin
        if (!aresetn) begin
            range_lo = RANGE_LOW_RST;
            range_hi = RANGE_HIGH_RST;
            colour_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (colour_q.size() == 0) begin
                    $display("%0t ns: unexpected word, expected none, got %h", $time, got);
                    fail_count++;
                end else begin
                    want = colour_q.pop_front();
                    checked_words++;
                    for (int i = 0; i < 3; i++) begin
                        if (want[i*CHAN_W +: CHAN_W] != got[i*CHAN_W +: CHAN_W]) begin
                            $display("%0t ns: %s expected %0d, got %0d", $time, field_name[i],
                                     want[i*CHAN_W +: CHAN_W], got[i*CHAN_W +: CHAN_W]);
                            fail_count++;
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                colour_q.insert(colour_q.size(),
                                jet_colour(s_tdata[SAMPLE_WIDTH_DEF-1:0], range_lo, range_hi));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RANGE_LOW:  range_lo = cfg_data;
                    REG_RANGE_HIGH: range_hi = cfg_data;
                    default: ;
                endcase
            end
        end
        pending_words = colour_q.size();
    end

endmodule

[sim/jet_false_color_map_tb.sv]
// Top of the jet false-colour mapper testbench: clock, reset, range writes,
// sample stimulus with random idling and stalls, and the final verdict.
// Depends on jfcm_pkg, jet_false_color_map and jfcm_checker.
`timescale 1ns / 1ps

module jet_false_color_map_tb;
    import jfcm_pkg::*;

    localparam int SW      = SAMPLE_WIDTH_DEF;
    localparam int TDATA_W = ((SW + 7) / 8) * 8;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;      // sample_value
    logic                 m_tvalid;
    logic                 m_tready  = 1'b1;
    logic [3*CHAN_W-1:0]  m_tdata;             // blue_out, green_out, red_out
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_RANGE_LOW;
    logic [REG_W-1:0]     cfg_data  = '0;

    int fail_count;
    int checked_words;
    int pending_words;
    int src_idle   = 0;
    int sink_stall = 0;
    int sent_words = 0;
    int range_writes = 0;
    int cur_lo = 0;
    int cur_hi = 32767;

    jet_false_color_map #(.SAMPLE_WIDTH(SW)) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    jfcm_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .checked_words (checked_words),
        .pending_words (pending_words)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    // Hard stop
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Offer one sample, idling first at random; valid stays high afterwards
    task automatic send_sample(input logic signed [SW-1:0] v);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(v);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_words++;
        @(negedge aclk);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_words != 0) @(negedge aclk);
    endtask

    // Write both range registers while the block is idle
    task automatic write_range(input int lo, input int hi);
        drain_pipe();
        cfg_valid <= 1'b1;
        cfg_index <= REG_RANGE_LOW;
        cfg_data  <= REG_W'(lo);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_index <= REG_RANGE_HIGH;
        cfg_data  <= REG_W'(hi);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
        range_writes++;
    endtask

    // Pick a range: full random, full scale, narrow, narrow swapped or zero span
    task automatic pick_range();
        int a;
        int d;
        a = $signed(16'($urandom()));
        d = int'($urandom_range(40, 1));
        case ($urandom_range(4))
            0: write_range(a, $signed(16'($urandom())));
            1: write_range(-32768, 32767);
            2: write_range(a, (a + d > 32767) ? 32767 : a + d);
            3: write_range((a + d > 32767) ? 32767 : a + d, a);
            default: write_range(a, a);
        endcase
    endtask

    // Mostly samples in and just around the range, the rest any 16-bit value
    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        int lo;
        int hi;
        src_idle   = idle_pct;
        sink_stall = stall_pct;
        pick_range();
        lo = ((cur_lo < cur_hi) ? cur_lo : cur_hi) - 2;
        hi = ((cur_lo < cur_hi) ? cur_hi : cur_lo) + 2;
        if (lo < -32768) lo = -32768;
        if (hi > 32767)  hi = 32767;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 70) begin
                send_sample(SW'(lo + int'($urandom_range(hi - lo))));
            end else begin
                send_sample(SW'($urandom()));
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset range 0..32767: extremes, segment edges, below range, top of range
        send_sample(-16'sd32768);
        send_sample(-16'sd100);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(16'sd8191);
        send_sample(16'sd8192);
        send_sample(16'sd16383);
        send_sample(16'sd16384);
        send_sample(16'sd24575);
        send_sample(16'sd24576);
        send_sample(16'sd32766);
        send_sample(16'sd32767);

        // Swapped extremes
        write_range(32767, -32768);
        send_sample(-16'sd32768);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd32767);

        // Zero span: everything clamps to the bound
        write_range(100, 100);
        send_sample(16'sd99);
        send_sample(16'sd100);
        send_sample(16'sd101);
        send_sample(-16'sd32768);

        // Random part: four phases of source idling and sink stalls, two ranges each
        for (int r = 0; r < 2; r++) run_phase(0, 0, 50);
        for (int r = 0; r < 2; r++) run_phase(45, 0, 50);
        for (int r = 0; r < 2; r++) run_phase(0, 45, 50);
        for (int r = 0; r < 2; r++) run_phase(22, 22, 50);

        drain_pipe();
        repeat (40) @(negedge aclk);

        $display("Sent %0d samples over %0d range settings, checked %0d colour words.",
                 sent_words, range_writes + 1, checked_words);
        $display("Ranges covered reset, full scale, swapped, narrow and zero span; %0d failures.",
                 fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
